### sv/local_date_to_epoch_seconds_assert.svh
// Assertion macros for the local date to epoch seconds block.
// Included by the top level; no other dependencies.
`ifndef LOCAL_DATE_TO_EPOCH_SECONDS_ASSERT_SVH
`define LOCAL_DATE_TO_EPOCH_SECONDS_ASSERT_SVH

// same-cycle implication
`define LDTE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ldte assertion failed");

// next-cycle implication
`define LDTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ldte assertion failed");

`endif

### sv/ldte_pkg.sv
// Shared widths, constants and the month start table of the date to epoch block.
// No dependencies.
package ldte_pkg;

   localparam int YEAR_W   = 8;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int OFFSET_W = 17;
   localparam int EPOCH_W  = 33;

   localparam int DAYS_W   = 17;   // day count since 1970
   localparam int TOD_W    = 17;   // seconds within the day, unchecked fields
   localparam int ADJ_W    = 19;   // time of day minus offset, signed
   localparam int MSTART_W = 9;

   localparam int EPOCH_TO_BASE_DAYS = 10957;   // 1970-01-01 to 2000-01-01
   localparam int DAYS_COMMON_YEAR   = 365;
   localparam int SECS_DAY           = 86400;
   localparam int SECS_HOUR          = 3600;
   localparam int SECS_MINUTE        = 60;
   localparam int MONTHS_PER_YEAR    = 12;
   localparam int CENTURY_ONE        = 100;   // year 2100, not leap
   localparam int CENTURY_TWO        = 200;   // year 2200, not leap

   typedef struct packed {
      logic advance;
   } pipe_ctl_type;

   // days before the first of the month that follows full_months whole months
   function automatic logic [MSTART_W-1:0] month_start_days(
      input logic [MONTH_W-1:0] full_months,
      input logic               leap
   );
      logic [MSTART_W-1:0] base;
      unique case (full_months)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         default: base = 9'd365;
      endcase
      if (leap && (full_months >= 4'd2)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

### sv/ldte_calendar.sv
// Stage one: calendar fields to a day count since 1970 and seconds of the day.
// Depends on ldte_pkg.
module ldte_calendar (
   input  logic                            clock,
   input  logic                            reset,
   input  ldte_pkg::pipe_ctl_type          ctl,
   input  logic                            in_valid,
   input  logic [ldte_pkg::YEAR_W-1:0]     year_offset,
   input  logic [ldte_pkg::MONTH_W-1:0]    month_number,
   input  logic [ldte_pkg::DAY_W-1:0]      day_of_month,
   input  logic [ldte_pkg::HOUR_W-1:0]     hour_of_day,
   input  logic [ldte_pkg::MINUTE_W-1:0]   minute_of_hour,
   input  logic [ldte_pkg::SECOND_W-1:0]   second_of_minute,
   output logic                            s1_valid,
   output logic [ldte_pkg::DAYS_W-1:0]     s1_days,
   output logic [ldte_pkg::TOD_W-1:0]      s1_tod
);
   import ldte_pkg::*;

   logic                 valid_ff, valid_in;
   logic [DAYS_W-1:0]    days_ff, days_in;
   logic [TOD_W-1:0]     tod_ff, tod_in;

   logic [YEAR_W:0]      yo_ext;
   logic [6:0]           leap_count;
   logic                 leap;
   logic [MONTH_W-1:0]   full_months;
   logic [MSTART_W-1:0]  month_start;
   logic [DAYS_W-1:0]    year_days;

   always_comb begin
      yo_ext = {1'b0, year_offset};
      // leap years in [2000, year): multiples of four, less skipped centuries
      leap_count = 7'((yo_ext + 9'd3) >> 2);
      if (yo_ext > 9'(CENTURY_ONE)) begin
         leap_count = leap_count - 7'd1;
      end
      if (yo_ext > 9'(CENTURY_TWO)) begin
         leap_count = leap_count - 7'd1;
      end
      leap = (year_offset[1:0] == 2'b00) && (yo_ext != 9'(CENTURY_ONE))
             && (yo_ext != 9'(CENTURY_TWO));

      priority if (month_number == '0) begin
         full_months = '0;
      end else if (month_number > MONTH_W'(MONTHS_PER_YEAR)) begin
         full_months = MONTH_W'(MONTHS_PER_YEAR);
      end else begin
         full_months = month_number - MONTH_W'(1);
      end
      month_start = month_start_days(full_months, leap);

      year_days = DAYS_W'(year_offset) * DAYS_W'(DAYS_COMMON_YEAR);
      days_in = DAYS_W'(EPOCH_TO_BASE_DAYS) + year_days + DAYS_W'(leap_count)
                + DAYS_W'(month_start) + DAYS_W'(day_of_month) - DAYS_W'(1);
      tod_in = TOD_W'(hour_of_day) * TOD_W'(SECS_HOUR)
               + TOD_W'(minute_of_hour) * TOD_W'(SECS_MINUTE)
               + TOD_W'(second_of_minute);
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         days_ff <= days_in;
         tod_ff  <= tod_in;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_days  = days_ff;
   assign s1_tod   = tod_ff;

endmodule

### sv/ldte_scale.sv
// Stage two: day count times seconds per day, time of day less the UTC offset.
// Depends on ldte_pkg.
module ldte_scale (
   input  logic                            clock,
   input  logic                            reset,
   input  ldte_pkg::pipe_ctl_type          ctl,
   input  logic                            s1_valid,
   input  logic [ldte_pkg::DAYS_W-1:0]     s1_days,
   input  logic [ldte_pkg::TOD_W-1:0]      s1_tod,
   input  logic [ldte_pkg::OFFSET_W-1:0]   utc_offset,
   output logic                            s2_valid,
   output logic [ldte_pkg::EPOCH_W-1:0]    s2_product,
   output logic [ldte_pkg::ADJ_W-1:0]      s2_tod_adj
);
   import ldte_pkg::*;

   logic                  valid_ff;
   logic [EPOCH_W-1:0]    product_ff, product_in;
   logic [ADJ_W-1:0]      tod_adj_ff, tod_adj_in;
   logic [EPOCH_W:0]      product_full;

   always_comb begin
      product_full = (EPOCH_W+1)'(s1_days) * (EPOCH_W+1)'(SECS_DAY);
      product_in   = product_full[EPOCH_W-1:0];
      // two's complement difference, sign carried in the top bit
      tod_adj_in   = {{(ADJ_W-TOD_W){1'b0}}, s1_tod}
                     - {{(ADJ_W-OFFSET_W){utc_offset[OFFSET_W-1]}}, utc_offset};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         product_ff <= product_in;
         tod_adj_ff <= tod_adj_in;
      end
   end

   assign s2_valid   = valid_ff;
   assign s2_product = product_ff;
   assign s2_tod_adj = tod_adj_ff;

endmodule

### sv/local_date_to_epoch_seconds.sv
// Local calendar time to Unix epoch seconds: top level, offset register, output stage.
// Depends on ldte_pkg, ldte_calendar, ldte_scale and the assertion header.
//
// Takes one word per cycle unless the pipe is held, and returns its epoch seconds
// through three register stages: day count and time of day from the calendar
// fields, the 17 x 17 bit multiply by seconds per day with the UTC offset
// applied, and the final 33 bit add in the output register. The Gregorian rule
// holds for all years, so 2100 and 2200 are common years. Fields are not checked
// against month length; the result wraps modulo 2^33. rsp_stall holds the whole
// pipe, and req_stall follows it in the same cycle while a result waits.
// csr_wr_data is the signed UTC offset, local minus UTC, written whenever
// csr_wr_en is high; it resets to zero.
`include "local_date_to_epoch_seconds_assert.svh"

module local_date_to_epoch_seconds (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ldte_pkg::YEAR_W-1:0]     req_year_offset,
   input  logic [ldte_pkg::MONTH_W-1:0]    req_month_number,
   input  logic [ldte_pkg::DAY_W-1:0]      req_day_of_month,
   input  logic [ldte_pkg::HOUR_W-1:0]     req_hour_of_day,
   input  logic [ldte_pkg::MINUTE_W-1:0]   req_minute_of_hour,
   input  logic [ldte_pkg::SECOND_W-1:0]   req_second_of_minute,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ldte_pkg::EPOCH_W-1:0]    rsp_epoch_seconds,
   input  logic                            csr_wr_en,
   input  logic [ldte_pkg::OFFSET_W-1:0]   csr_wr_data
);
   import ldte_pkg::*;

   pipe_ctl_type          ctl;
   logic [OFFSET_W-1:0]   offset_ff;
   logic                  s1_valid, s2_valid;
   logic [DAYS_W-1:0]     s1_days;
   logic [TOD_W-1:0]      s1_tod;
   logic [EPOCH_W-1:0]    s2_product;
   logic [ADJ_W-1:0]      s2_tod_adj;
   logic                  out_valid_ff;
   logic [EPOCH_W-1:0]    epoch_ff, epoch_in;

   // whole pipe moves unless a result sits at the output and is stalled
   assign ctl.advance = !(out_valid_ff && rsp_stall);
   assign req_stall   = !ctl.advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr_wr_en) begin
         offset_ff <= csr_wr_data;
      end
   end

   ldte_calendar u_calendar (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .in_valid         (req_valid),
      .year_offset      (req_year_offset),
      .month_number     (req_month_number),
      .day_of_month     (req_day_of_month),
      .hour_of_day      (req_hour_of_day),
      .minute_of_hour   (req_minute_of_hour),
      .second_of_minute (req_second_of_minute),
      .s1_valid         (s1_valid),
      .s1_days          (s1_days),
      .s1_tod           (s1_tod)
   );

   ldte_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .s1_valid   (s1_valid),
      .s1_days    (s1_days),
      .s1_tod     (s1_tod),
      .utc_offset (offset_ff),
      .s2_valid   (s2_valid),
      .s2_product (s2_product),
      .s2_tod_adj (s2_tod_adj)
   );

   assign epoch_in = s2_product + {{(EPOCH_W-ADJ_W){s2_tod_adj[ADJ_W-1]}}, s2_tod_adj};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         out_valid_ff <= s2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         epoch_ff <= epoch_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_epoch_seconds = epoch_ff;

   `LDTE_ASSERT_NEXT(a_s1_to_s2, clock, reset, s1_valid && ctl.advance, s2_valid)
   `LDTE_ASSERT_NEXT(a_s2_to_out, clock, reset, s2_valid && ctl.advance, rsp_valid)
   `LDTE_ASSERT_NEXT(a_hold_s2, clock, reset, s2_valid && !ctl.advance, s2_valid && $stable(s2_product))

endmodule

### sim/testbench.sv
// Self-checking bench for local_date_to_epoch_seconds: queue-fed driver, clocked
// monitor and a calendar predictor for the expected epoch seconds.
// Depends on ldte_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
   import ldte_pkg::*;

   localparam int EPOCH_YEAR     = 1970;
   localparam int BASE_YEAR      = 2000;
   localparam int LONG_HOLD      = 80;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_WORDS   = 500;
   localparam int MAX_REPORTS    = 200;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } cal_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   cal_word_type        req_word = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [EPOCH_W-1:0]  rsp_epoch_seconds;
   logic                csr_wr_en = 1'b0;
   logic [OFFSET_W-1:0] csr_wr_data = '0;

   logic                       req_fire = 1'b0;
   logic signed [OFFSET_W-1:0] tz_offset = '0;
   cal_word_type               pending_dates[$];
   logic [EPOCH_W-1:0]         expected_epochs[$];
   int                         words_queued = 0;
   int                         words_checked = 0;
   int                         error_count = 0;
   int                         src_idle_pct = 0;
   int                         snk_idle_pct = 0;
   int                         hold_requests = 0;
   int                         hold_seen = 0;
   int                         hold_left = 0;
   int                         quiet_cycles = 0;

   local_date_to_epoch_seconds DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_year_offset      (req_word.year),
      .req_month_number     (req_word.month),
      .req_day_of_month     (req_word.day),
      .req_hour_of_day      (req_word.hour),
      .req_minute_of_hour   (req_word.minute),
      .req_second_of_minute (req_word.second),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_epoch_seconds    (rsp_epoch_seconds),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit greg_leap(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic logic [EPOCH_W-1:0] epoch_of(cal_word_type w,
                                                   logic signed [OFFSET_W-1:0] ofs);
      longint unsigned acc;
      int unsigned     yr;
      int unsigned     full_months;
      int unsigned     mlen;
      bit              leap;
      acc  = 0;
      yr   = BASE_YEAR + w.year;
      leap = greg_leap(yr);
      for (int unsigned y = EPOCH_YEAR; y < yr; y++) begin
         acc += (greg_leap(y) ? DAYS_COMMON_YEAR + 1 : DAYS_COMMON_YEAR) * SECS_DAY;
      end
      // month 0 acts as January, anything past December counts all twelve
      full_months = (w.month == 0) ? 0 : w.month - 1;
      if (full_months > MONTHS_PER_YEAR) begin
         full_months = MONTHS_PER_YEAR;
      end
      for (int unsigned m = 1; m <= full_months; m++) begin
         unique case (m)
            2:           mlen = leap ? 29 : 28;
            4, 6, 9, 11: mlen = 30;
            default:     mlen = 31;
         endcase
         acc += longint'(mlen) * SECS_DAY;
      end
      acc += longint'(w.day) * SECS_DAY;
      acc -= SECS_DAY;
      acc += longint'(w.hour) * SECS_HOUR;
      acc += longint'(w.minute) * SECS_MINUTE;
      acc += longint'(w.second);
      acc -= longint'(ofs);
      return acc[EPOCH_W-1:0];
   endfunction

   // driver: a word stays put until taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_dates.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
            req_word  <= pending_dates.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with a long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < snk_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : monitor
      logic [EPOCH_W-1:0] want;
      if (reset) begin
         req_fire  <= 1'b0;
         tz_offset <= '0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (csr_wr_en) begin
            tz_offset <= csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            expected_epochs.push_back(epoch_of(req_word, tz_offset));
         end
         if (rsp_valid && !rsp_stall) begin
            words_checked <= words_checked + 1;
            if (expected_epochs.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t ERR unexpected word: expected none, got %0d",
                           $time, rsp_epoch_seconds);
               end
            end else begin
               want = expected_epochs.pop_front();
               if (rsp_epoch_seconds !== want) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $display("%0t ERR epoch_seconds: expected %0d, got %0d",
                              $time, want, rsp_epoch_seconds);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no progress", $time);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic queue_date(int y, int mo, int d, int h, int mi, int s);
      cal_word_type w;
      w.year   = YEAR_W'(y);
      w.month  = MONTH_W'(mo);
      w.day    = DAY_W'(d);
      w.hour   = HOUR_W'(h);
      w.minute = MINUTE_W'(mi);
      w.second = SECOND_W'(s);
      pending_dates.push_back(w);
      words_queued++;
   endtask

   task automatic queue_random_dates(int count);
      @(posedge clock);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            // full field widths, out-of-range values included
            queue_date($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         end else begin
            queue_date($urandom_range(0, 199), $urandom_range(1, 12), $urandom_range(1, 31),
                       $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (words_checked != words_queued);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_idle(int src_pct, int snk_pct);
      @(posedge clock);
      src_idle_pct = src_pct;
      snk_idle_pct = snk_pct;
   endtask

   task automatic write_offset(int value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[OFFSET_W-1:0];
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      set_idle(15, 49);

      @(posedge clock);
      queue_date(0, 1, 1, 0, 0, 0);
      queue_date(199, 12, 31, 23, 59, 59);
      queue_date(0, 2, 29, 12, 0, 0);        // 2000 is leap
      queue_date(0, 3, 1, 0, 0, 0);
      queue_date(100, 2, 28, 23, 59, 59);    // 2100 is not
      queue_date(100, 3, 1, 0, 0, 0);
      queue_date(96, 12, 31, 23, 59, 59);
      queue_date(200, 3, 1, 0, 0, 0);        // past 2199
      queue_date(255, 15, 31, 31, 63, 63);   // everything saturated, sum wraps
      queue_date(0, 0, 0, 0, 0, 0);
      queue_date(55, 0, 15, 6, 30, 30);
      queue_date(55, 13, 1, 0, 0, 0);
      queue_date(55, 12, 0, 0, 0, 0);
      queue_date(38, 1, 19, 3, 14, 7);
      queue_date(170, 2, 31, 0, 0, 0);
      queue_date(10, 6, 15, 24, 60, 60);
      wait_drained();

      write_offset(-50400);
      queue_random_dates(RANDOM_WORDS);
      repeat (40) @(posedge clock);
      hold_requests++;
      wait_drained();

      set_idle(49, 15);
      write_offset(50400);
      queue_random_dates(RANDOM_WORDS);
      wait_drained();

      set_idle(0, 0);
      write_offset(int'($urandom_range(0, 100800)) - 50400);
      queue_random_dates(RANDOM_WORDS);
      wait_drained();

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
